>>> design/clsr_pkg.sv
// shared constants, command struct and arithmetic helpers for the shuffled combined generator
package clsr_pkg;

    localparam int unsigned TABLE_DEPTH = 32;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned WORD_W      = 31;
    localparam int unsigned MULT_W      = 16;
    localparam int unsigned PROD_W      = WORD_W + MULT_W;
    localparam int unsigned FOLD_W      = 8;
    localparam int unsigned WARM_W      = $clog2(TABLE_DEPTH + 8);

    localparam logic [MULT_W-1:0] GEN_A1 = 16'd40014;
    localparam logic [MULT_W-1:0] GEN_A2 = 16'd40692;
    localparam logic [WORD_W-1:0] GEN_M1 = 31'd2147483563;
    localparam logic [WORD_W-1:0] GEN_M2 = 31'd2147483399;
    localparam logic [WORD_W-1:0] GEN_MM1 = GEN_M1 - 31'd1;
    localparam logic [WORD_W-1:0] GEN2_RESET = 31'd123456789;

    // modulus = 2^31 - fold constant
    localparam logic [FOLD_W-1:0] GEN_C1 = FOLD_W'(32'h8000_0000 - {1'b0, GEN_M1});
    localparam logic [FOLD_W-1:0] GEN_C2 = FOLD_W'(32'h8000_0000 - {1'b0, GEN_M2});

    // slot = last / SLOT_DIV via reciprocal estimate plus one correction
    localparam longint unsigned SLOT_DIV   = 64'd1 + 64'(GEN_MM1) / 64'(TABLE_DEPTH);
    localparam int unsigned     SLOT_SHIFT = 37;
    localparam longint unsigned SLOT_RECIP = (64'd1 << SLOT_SHIFT) / SLOT_DIV;
    localparam int unsigned     RECIP_W    = $clog2(SLOT_RECIP + 64'd1);
    localparam int unsigned     RPROD_W    = WORD_W + RECIP_W;
    localparam int unsigned     QUOT_W     = $clog2(TABLE_DEPTH + 2);
    localparam int unsigned     THR_W      = WORD_W + QUOT_W;

    typedef struct packed {
        logic              load_seed;
        logic              mul;
        logic              step_first;
        logic              step_second;
        logic              calc_slot;
        logic              warm_wr;
        logic              warm_last;
        logic              rd_table;
        logic              finish;
        logic [WARM_W-1:0] warm_addr;
    } cmd_t;

    // reduce a*z modulo 2^31 - c, product below 2^47
    function automatic logic [WORD_W-1:0] mod_fold(
        input logic [PROD_W-1:0] prod,
        input logic [FOLD_W-1:0] fold_c,
        input logic [WORD_W-1:0] modulus
    );
        logic [MULT_W+FOLD_W-1:0] hi_term;
        logic [WORD_W:0]          sum;
        hi_term = {{FOLD_W{1'b0}}, prod[PROD_W-1:WORD_W]} * {{MULT_W{1'b0}}, fold_c};
        sum = {{(WORD_W + 1 - MULT_W - FOLD_W){1'b0}}, hi_term} + {1'b0, prod[WORD_W-1:0]};
        if (sum >= {1'b0, modulus})
        begin
            sum = sum - {1'b0, modulus};
        end
        return sum[WORD_W-1:0];
    endfunction

    // k * SLOT_DIV
    function automatic logic [THR_W-1:0] slot_threshold(input logic [QUOT_W-1:0] k);
        return {{WORD_W{1'b0}}, k} * THR_W'(SLOT_DIV);
    endfunction

endpackage

>>> design/clsr_datapath.sv
// generators, slot divider, shuffle memory and sample arithmetic
module clsr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  clsr_pkg::cmd_t                 cmd,
    input  logic [clsr_pkg::WORD_W-1:0]    seed,
    output logic [clsr_pkg::WORD_W-1:0]    sample
);
    import clsr_pkg::*;

    logic [WORD_W-1:0]  g1_reg;
    logic [WORD_W-1:0]  g2_reg;
    logic [WORD_W-1:0]  last_reg;
    logic [PROD_W-1:0]  prod1_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [QUOT_W-1:0]  qest_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;
    logic [WORD_W-1:0]  sample_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [WORD_W-1:0]  shuf_mem [TABLE_DEPTH];

    logic [WORD_W-1:0]  seed_eff;
    logic [WORD_W-1:0]  g1_fold;
    logic [WORD_W-1:0]  g2_fold;
    logic [PROD_W-1:0]  prod1_next;
    logic [PROD_W-1:0]  prod2_next;
    logic [RPROD_W-1:0] recip_prod;
    logic [QUOT_W-1:0]  quot_inc;
    logic [QUOT_W-1:0]  quot;
    logic [ADDR_W-1:0]  slot_next;
    logic [THR_W-1:0]   thr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  tbl_word;
    logic [WORD_W:0]    diff;
    logic [WORD_W-1:0]  sample_next;

    assign seed_eff   = (seed == '0) ? WORD_W'(1) : seed;
    assign prod1_next = {{WORD_W{1'b0}}, GEN_A1} * {{MULT_W{1'b0}}, g1_reg};
    assign prod2_next = {{WORD_W{1'b0}}, GEN_A2} * {{MULT_W{1'b0}}, g2_reg};
    assign g1_fold    = mod_fold(prod1_reg, GEN_C1, GEN_M1);
    assign g2_fold    = mod_fold(prod2_reg, GEN_C2, GEN_M2);
    assign recip_prod = {{RECIP_W{1'b0}}, last_reg} * {{WORD_W{1'b0}}, RECIP_W'(SLOT_RECIP)};

    always_comb
    begin
        quot_inc = qest_reg + QUOT_W'(1);
        thr      = slot_threshold(quot_inc);
        quot     = ({{QUOT_W{1'b0}}, last_reg} >= thr) ? quot_inc : qest_reg;
        if (quot > QUOT_W'(TABLE_DEPTH - 1))
        begin
            slot_next = ADDR_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            slot_next = quot[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        tbl_word = rd_valid_reg ? rd_data_reg : '0;
        if (tbl_word > g2_reg)
        begin
            diff = {1'b0, tbl_word} - {1'b0, g2_reg};
        end
        else
        begin
            diff = {1'b0, tbl_word} + {1'b0, GEN_MM1} - {1'b0, g2_reg};
        end
        sample_next = diff[WORD_W-1:0];
    end

    assign wr_en   = cmd.warm_wr | cmd.finish;
    assign wr_addr = cmd.warm_wr ? cmd.warm_addr[ADDR_W-1:0] : slot_reg;
    assign wr_data = cmd.warm_wr ? g1_fold : g1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg    <= WORD_W'(1);
            g2_reg    <= GEN2_RESET;
            last_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                g1_reg <= seed_eff;
                g2_reg <= seed_eff;
            end
            else
            begin
                if (cmd.step_first)
                begin
                    g1_reg <= g1_fold;
                end
                if (cmd.step_second)
                begin
                    g2_reg <= g2_fold;
                end
            end
            if (cmd.warm_last)
            begin
                last_reg <= g1_fold;
            end
            else if (cmd.finish)
            begin
                last_reg <= sample_next;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
            qest_reg  <= recip_prod[SLOT_SHIFT +: QUOT_W];
        end
        if (cmd.calc_slot)
        begin
            slot_reg <= slot_next;
        end
        if (cmd.finish)
        begin
            sample_reg <= sample_next;
        end
    end

    // shuffle memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shuf_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_table)
        begin
            rd_data_reg  <= shuf_mem[slot_reg];
            rd_valid_reg <= valid_reg[slot_reg];
        end
    end

    assign sample = sample_reg;

endmodule

>>> design/clsr_ctrl.sv
// sequencer for warm-up, draw steps and the output register handshake
module clsr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           reseed,
    output logic           m_tvalid,
    input  logic           m_tready,
    output clsr_pkg::cmd_t cmd
);
    import clsr_pkg::*;

    typedef enum logic [6:0] {
        IDLE  = 7'b0000001,
        WMUL  = 7'b0000010,
        WFOLD = 7'b0000100,
        MUL   = 7'b0001000,
        FOLD  = 7'b0010000,
        READ  = 7'b0100000,
        OUT   = 7'b1000000
    } state_t;

    localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(TABLE_DEPTH + 7);

    state_t            state_reg;
    state_t            state_next;
    logic [WARM_W-1:0] n_reg;
    logic [WARM_W-1:0] n_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.warm_addr = n_reg;
        state_next    = state_reg;
        n_next        = n_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_seed = reseed;
                    n_next        = WARM_LAST;
                    state_next    = reseed ? WMUL : MUL;
                end
            end
            WMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = WFOLD;
            end
            WFOLD:
            begin
                cmd.step_first = 1'b1;
                cmd.warm_wr    = (n_reg < WARM_W'(TABLE_DEPTH));
                if (n_reg == '0)
                begin
                    cmd.warm_last = 1'b1;
                    state_next    = MUL;
                end
                else
                begin
                    n_next     = n_reg - WARM_W'(1);
                    state_next = WMUL;
                end
            end
            MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = FOLD;
            end
            FOLD:
            begin
                cmd.step_first  = 1'b1;
                cmd.step_second = 1'b1;
                cmd.calc_slot   = 1'b1;
                state_next      = READ;
            end
            READ:
            begin
                cmd.rd_table = 1'b1;
                state_next   = OUT;
            end
            OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_reseed_starts_warmup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && reseed) |=> (state_reg == WMUL && n_reg == WARM_LAST))
        else $error("reseed item did not start warm-up");
    a_warmup_ends_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WFOLD && n_reg == '0) |=> (state_reg == MUL))
        else $error("warm-up did not hand over to draw");
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == OUT))
        else $error("result appeared outside output step");
    a_draw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FOLD) |=> (state_reg == READ) ##1 (state_reg == OUT))
        else $error("draw steps out of order");
`endif

endmodule

>>> design/combined_lcg_shuffle_rng_top.sv
// top level: stream ports, seed register and controller/datapath wiring
// an accepted draw item passes the MUL, FOLD, READ and OUT states before m_tvalid; OUT
// waits for the output register, and a new item is taken only after the result is registered
// reseed adds TABLE_DEPTH+8 warm-up steps (WMUL, then WFOLD): the first generator's
// multiply and fold run once per warm-up step
// reset: generators load 1 and 123456789, seed register 1, table reads as zero
module combined_lcg_shuffle_rng_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] reseed, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] sample, [31] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import clsr_pkg::*;

    localparam logic REG_SEED = 1'b0;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] sample;
    logic              cfg_wr;
    cmd_t              cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign prdata = (paddr[2] == REG_SEED) ? {1'b0, seed_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= WORD_W'(1);
        end
        else if (cfg_wr)
        begin
            seed_reg <= pwdata[WORD_W-1:0];
        end
    end

    clsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .reseed   (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    clsr_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .seed   (seed_reg),
        .sample (sample)
    );

    assign m_tdata = {1'b0, sample};

endmodule

>>> test/combined_lcg_shuffle_rng_top_tb.sv
// self-checking testbench for the shuffled combined generator: stream draws, seed writes, backpressure
module combined_lcg_shuffle_rng_top_tb;
    import clsr_pkg::*;

    localparam longint SCH_Q1 = 53668;
    localparam longint SCH_R1 = 12211;
    localparam longint SCH_Q2 = 52774;
    localparam longint SCH_R2 = 3791;
    localparam logic [2:0] SEED_ADDR = 3'd0;
    localparam int HOLD_CYCLES = 300;

    typedef enum {PH_PLAIN, PH_BACKPRESSURE, PH_PAUSE} phase_kind_t;

    class rng_scoreboard;
        bit [WORD_W-1:0] seed_reg;
        bit [WORD_W-1:0] gen1;
        bit [WORD_W-1:0] gen2;
        bit [WORD_W-1:0] prev_sample;
        bit [WORD_W-1:0] slots [TABLE_DEPTH];
        bit [WORD_W-1:0] pending [$];
        int failures;

        function new();
            seed_reg = 31'd1;
            gen1 = 31'd1;
            gen2 = 31'd123456789;
            prev_sample = '0;
            foreach (slots[i])
                slots[i] = '0;
            failures = 0;
        endfunction

        function bit [WORD_W-1:0] congruential_step(input bit [WORD_W-1:0] z, input longint a,
                                                     input longint q, input longint r,
                                                     input longint m);
            longint v;
            longint k;
            v = z;
            k = v / q;
            v = a * (v - k * q) - k * r;
            if (v < 0)
                v += m;
            return v[WORD_W-1:0];
        endfunction

        function bit [WORD_W-1:0] step_first(input bit [WORD_W-1:0] z);
            return congruential_step(z, longint'(GEN_A1), SCH_Q1, SCH_R1, longint'(GEN_M1));
        endfunction

        function bit [WORD_W-1:0] step_second(input bit [WORD_W-1:0] z);
            return congruential_step(z, longint'(GEN_A2), SCH_Q2, SCH_R2, longint'(GEN_M2));
        endfunction

        function void set_seed(input bit [WORD_W-1:0] v);
            seed_reg = v;
        endfunction

        function void note_request(input bit reseed);
            bit [WORD_W-1:0] start;
            longint unsigned idx;
            longint diff;
            int n;
            if (reseed)
            begin
                start = (seed_reg == '0) ? 31'd1 : seed_reg;
                gen1 = start;
                gen2 = start;
                for (n = int'(TABLE_DEPTH) + 7; n >= 0; n--)
                begin
                    gen1 = step_first(gen1);
                    if (n < int'(TABLE_DEPTH))
                        slots[n] = gen1;
                end
                prev_sample = slots[0];
            end
            gen1 = step_first(gen1);
            gen2 = step_second(gen2);
            idx = longint'(prev_sample) / SLOT_DIV;
            if (idx >= TABLE_DEPTH)
                idx = TABLE_DEPTH - 1;
            diff = longint'(slots[idx]) - longint'(gen2);
            slots[idx] = gen1;
            if (diff < 1)
                diff += longint'(GEN_MM1);
            prev_sample = diff[WORD_W-1:0];
            pending.push_back(prev_sample);
        endfunction

        function void check_sample(input bit [WORD_W-1:0] got);
            bit [WORD_W-1:0] want;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected sample %0d with nothing pending", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("sample mismatch: expected %0d got %0d", want, got);
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function int finish_check();
            if (pending.size() != 0)
            begin
                failures += pending.size();
                $display("%0d samples never arrived", pending.size());
            end
            return failures;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] reseed, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [30:0] sample, [31] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rng_scoreboard sb;
    bit calm;
    bit hold_request;

    combined_lcg_shuffle_rng_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    task automatic send_item(input bit reseed, input int gap);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, reseed};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(reseed);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_seed(input bit [WORD_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= {1'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_seed(v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input bit [WORD_W-1:0] seed, input int count, input bit quiet,
                             input phase_kind_t kind);
        int i;
        drain_results();
        write_seed(seed);
        calm = quiet;
        for (i = 0; i < count; i++)
        begin
            if (kind == PH_BACKPRESSURE && i == count / 3)
                hold_request = 1'b1;
            if (kind == PH_PAUSE && i == count / 2)
                drain_results();
            send_item(i == 0 || $urandom_range(0, 19) == 0, pick_gap());
        end
        calm = 1'b0;
    endtask

    // receiver: random stalls plus one long hold on request
    initial
    begin
        int idle_left;
        idle_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_left == 0)
            begin
                if (hold_request)
                begin
                    idle_left = HOLD_CYCLES;
                    hold_request = 1'b0;
                end
                else if (!calm && $urandom_range(0, 3) == 0)
                    idle_left = pick_gap();
            end
            if (idle_left > 0)
            begin
                m_tready <= 1'b0;
                idle_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata[WORD_W-1:0]);
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        sb = new();
        calm = 1'b0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // draws from the reset state with an all-zero table, then reseeds from edge-case seed values
        repeat (3) send_item(1'b0, pick_gap());
        send_item(1'b1, pick_gap());
        send_item(1'b0, pick_gap());
        drain_results();
        write_seed('0);
        send_item(1'b1, pick_gap());
        send_item(1'b0, pick_gap());
        drain_results();
        write_seed(31'h7FFF_FFFF);
        send_item(1'b1, pick_gap());
        send_item(1'b0, pick_gap());
        drain_results();
        write_seed(GEN_M1);
        send_item(1'b1, pick_gap());
        drain_results();
        write_seed(31'd2147483562);
        send_item(1'b1, pick_gap());
        send_item(1'b0, pick_gap());
        drain_results();
        write_seed(31'h2AAA_AAAA);
        send_item(1'b1, pick_gap());
        drain_results();
        write_seed(31'h5555_5555);
        send_item(1'b1, pick_gap());
        send_item(1'b0, pick_gap());

        run_phase(WORD_W'($urandom_range(1, 2147483562)), 220, 1'b0, PH_PLAIN);
        run_phase(31'd1, 200, 1'b1, PH_PLAIN);
        run_phase(WORD_W'($urandom_range(1, 2147483562)), 220, 1'b0, PH_BACKPRESSURE);
        run_phase(31'd2147483562, 200, 1'b0, PH_PLAIN);
        run_phase(WORD_W'($urandom()), 200, 1'b0, PH_PAUSE);
        run_phase('0, 180, 1'b0, PH_PLAIN);
        run_phase(WORD_W'($urandom_range(1, 2147483562)), 220, 1'b0, PH_PLAIN);
        run_phase(31'h7FFF_FFFF, 190, 1'b0, PH_PLAIN);

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.finish_check() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
